/* rtl/smvu_pkg.sv */
// ----------------------------------------------------------------------------
// smvu_pkg
// Shared sizes, controller state codes, command/status bundles and the
// exponent step table for the softmax vector unit.
// ----------------------------------------------------------------------------
package smvu_pkg;

  // Vector store depth and derived widths
  localparam int MAX_ELEMENTS = 64;
  localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_BITS     = $clog2(MAX_ELEMENTS + 1);
  localparam int PTR_W        = (CNT_BITS > 6) ? CNT_BITS : 6;

  // Field and arithmetic widths
  localparam int WEIGHT_W  = 16;
  localparam int PROB_W    = 16;
  localparam int INDEX_W   = 6;
  localparam int SUM_W     = 24;
  localparam int EXP_W     = 17;  // Q1.16, up to 1.0
  localparam int DIV_W     = SUM_W + 1;
  localparam int EXP_STEPS = 12;
  localparam int DIV_STEPS = 16;

  // Controller states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SUM_RD,
    ST_SUM_XS,
    ST_SUM_EXP,
    ST_OUT_RD,
    ST_OUT_XS,
    ST_OUT_EXP,
    ST_DIV_XS,
    ST_DIV,
    ST_PUT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic take;       // input transaction accepted
    logic ptr_clr;
    logic ptr_inc;
    logic exp_start;  // start exponent on the element just read
    logic sum_add;    // accumulate the finished exponent
    logic div_start;  // start normalizing the finished exponent
    logic out_load;   // move quotient into the output register
    logic vec_clr;    // vector done, clear count, max and sum
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic exp_done;
    logic div_done;
    logic ptr_last;   // read pointer is on the final stored element
    logic out_free;   // output register can take a new result
  } sts_t;

  // round(65536 * exp(-2^k / 256)) for each bit k of the Q8.8 difference
  function automatic logic [15:0] exp_tab(input logic [3:0] k);
    logic [15:0] v;
    unique case (k)
      4'd0:    v = 16'd65280;
      4'd1:    v = 16'd65026;
      4'd2:    v = 16'd64520;
      4'd3:    v = 16'd63520;
      4'd4:    v = 16'd61565;
      4'd5:    v = 16'd57835;
      4'd6:    v = 16'd51039;
      4'd7:    v = 16'd39750;
      4'd8:    v = 16'd24109;
      4'd9:    v = 16'd8869;
      4'd10:   v = 16'd1200;
      4'd11:   v = 16'd22;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/smvu_ram.sv */
// ----------------------------------------------------------------------------
// smvu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smvu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/smvu_dp.sv */
// ----------------------------------------------------------------------------
// smvu_dp
// Datapath: weight store, running maximum, element count, bit-serial
// exponent unit, saturating sum, restoring divider and output register.
// ----------------------------------------------------------------------------
module smvu_dp import smvu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [WEIGHT_W-1:0] weight_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [PROB_W-1:0]   probability_o,
  output logic [INDEX_W-1:0]  element_index_o,
  output logic                last_result_o
);

  logic [PTR_W-1:0]    count_q, count_d;
  logic [PTR_W-1:0]    ptr_q, ptr_d, ptr_nx;
  logic [WEIGHT_W-1:0] max_q, max_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                store_en;
  logic [WEIGHT_W-1:0] rd_data;

  // exponent unit
  logic [EXP_STEPS-1:0] u_q, u_d;
  logic                 ez_q, ez_d;
  logic [EXP_W-1:0]     acc_q, acc_d;
  logic [3:0]           estep_q, estep_d;
  logic [EXP_W-1:0]     e_val;
  logic [16:0]          diff;
  logic [32:0]          prod;
  logic [33:0]          rnd;
  logic [SUM_W:0]       sum_ext;

  // divider
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W:0]    trial;
  logic              ge;
  logic [PROB_W-1:0] quo_q, quo_d;
  logic              sat_q, sat_d;
  logic [4:0]        dstep_q, dstep_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [PROB_W-1:0]   prob_q, prob_d;
  logic [INDEX_W-1:0]  idx_q, idx_d;
  logic                lastr_q, lastr_d;

  assign store_en = cmd_i.take && (count_q < PTR_W'(MAX_ELEMENTS));
  assign ptr_nx   = ptr_q + PTR_W'(1);

  smvu_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (weight_i),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  // Exponent step arithmetic: difference to max, one table multiply per bit
  assign diff    = {max_q[WEIGHT_W-1], max_q} - {rd_data[WEIGHT_W-1], rd_data};
  assign prod    = acc_q * exp_tab(estep_q);
  assign rnd     = {1'b0, prod} + 34'd32768;
  assign e_val   = ez_q ? '0 : acc_q;
  assign sum_ext = {1'b0, sum_q} + {{(SUM_W + 1 - EXP_W){1'b0}}, e_val};

  // Divider step: divisor is sum plus one epsilon LSB
  assign dvs   = {1'b0, sum_q} + DIV_W'(1);
  assign trial = {rem_q, 1'b0};
  assign ge    = trial >= {1'b0, dvs};

  // Vector bookkeeping
  always_comb begin
    count_d = count_q;
    ptr_d   = ptr_q;
    max_d   = max_q;
    sum_d   = sum_q;
    if (store_en) begin
      count_d = count_q + PTR_W'(1);
      if ($signed(weight_i) > $signed(max_q)) begin
        max_d = weight_i;
      end
    end
    if (cmd_i.sum_add) begin
      sum_d = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    end
    if (cmd_i.ptr_clr) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_nx;
    end
    if (cmd_i.vec_clr) begin
      count_d = '0;
      ptr_d   = '0;
      max_d   = {1'b1, {(WEIGHT_W-1){1'b0}}};
      sum_d   = '0;
    end
  end

  // Exponent unit: one bit of the difference per cycle
  always_comb begin
    u_d     = u_q;
    ez_d    = ez_q;
    acc_d   = acc_q;
    estep_d = estep_q;
    if (cmd_i.exp_start) begin
      u_d     = diff[EXP_STEPS-1:0];
      ez_d    = |diff[16:EXP_STEPS];
      acc_d   = EXP_W'(65536);
      estep_d = '0;
    end else if (estep_q != 4'(EXP_STEPS)) begin
      if (u_q[estep_q]) begin
        acc_d = rnd[32:16];
      end
      estep_d = estep_q + 4'd1;
    end
  end

  // Restoring divider: one quotient bit per cycle
  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    sat_d   = sat_q;
    dstep_d = dstep_q;
    if (cmd_i.div_start) begin
      sat_d   = {{(DIV_W - EXP_W){1'b0}}, e_val} >= dvs;
      rem_d   = {{(DIV_W - EXP_W){1'b0}}, e_val};
      quo_d   = '0;
      dstep_d = '0;
    end else if (dstep_q != 5'(DIV_STEPS)) begin
      rem_d   = ge ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
      quo_d   = {quo_q[PROB_W-2:0], ge};
      dstep_d = dstep_q + 5'd1;
    end
  end

  // Output register: hold while stalled, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    prob_d      = prob_q;
    idx_d       = idx_q;
    lastr_d     = lastr_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      prob_d      = sat_q ? '1 : quo_q;
      idx_d       = ptr_q[INDEX_W-1:0];
      lastr_d     = (ptr_nx == count_q);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      max_q       <= {1'b1, {(WEIGHT_W-1){1'b0}}};
      sum_q       <= '0;
      estep_q     <= 4'(EXP_STEPS);
      dstep_q     <= 5'(DIV_STEPS);
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      estep_q     <= estep_d;
      dstep_q     <= dstep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q     <= u_d;
    ez_q    <= ez_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    sat_q   <= sat_d;
    prob_q  <= prob_d;
    idx_q   <= idx_d;
    lastr_q <= lastr_d;
  end

  assign sts_o.exp_done = (estep_q == 4'(EXP_STEPS));
  assign sts_o.div_done = (dstep_q == 5'(DIV_STEPS));
  assign sts_o.ptr_last = (ptr_nx == count_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign probability_o   = prob_q;
  assign element_index_o = idx_q;
  assign last_result_o   = lastr_q;

endmodule

/* rtl/smvu_ctrl.sv */
// ----------------------------------------------------------------------------
// smvu_ctrl
// Controller: loads a vector, runs the sum pass, then the normalize pass
// and hands each probability to the output register.
// ----------------------------------------------------------------------------
module smvu_ctrl import smvu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic last_weight_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
        if (in_valid_i && last_weight_i) begin
          cmd_o.ptr_clr = 1'b1;
          state_d       = ST_SUM_RD;
        end
      end
      ST_SUM_RD: state_d = ST_SUM_XS;
      ST_SUM_XS: begin
        cmd_o.exp_start = 1'b1;
        state_d         = ST_SUM_EXP;
      end
      ST_SUM_EXP: begin
        if (sts_i.exp_done) begin
          cmd_o.sum_add = 1'b1;
          if (sts_i.ptr_last) begin
            cmd_o.ptr_clr = 1'b1;
            state_d       = ST_OUT_RD;
          end else begin
            cmd_o.ptr_inc = 1'b1;
            state_d       = ST_SUM_RD;
          end
        end
      end
      ST_OUT_RD: state_d = ST_OUT_XS;
      ST_OUT_XS: begin
        cmd_o.exp_start = 1'b1;
        state_d         = ST_OUT_EXP;
      end
      ST_OUT_EXP: begin
        if (sts_i.exp_done) begin
          state_d = ST_DIV_XS;
        end
      end
      ST_DIV_XS: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.ptr_last) begin
            cmd_o.vec_clr = 1'b1;
            state_d       = ST_LOAD;
          end else begin
            cmd_o.ptr_inc = 1'b1;
            state_d       = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

endmodule

/* rtl/softmax_vector_unit.sv */
// ----------------------------------------------------------------------------
// softmax_vector_unit
// Max-subtracted softmax over a vector of signed Q8.8 weights.
// ----------------------------------------------------------------------------
// Weights stream in one per cycle while the unit is loading; each is written
// to a 64-entry store and folded into the running maximum, and weights past
// the store depth are dropped. The transaction carrying last_weight closes the
// vector: the input stalls while the unit makes a sum pass (per stored
// element: one RAM read, one setup step, the bit-serial exponent multiplier
// and one accumulate step) and then a normalize pass (per element: the same
// exponent followed by a restoring divider and the output load).
// A closed vector therefore keeps the input stalled through both passes, plus
// any output stall. Probabilities leave in input order as unsigned Q0.16 from
// an output register; the next vector can start loading while the final
// probability still waits there.
// ----------------------------------------------------------------------------
module softmax_vector_unit import smvu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [WEIGHT_W-1:0] weight_i,
  input  logic                last_weight_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PROB_W-1:0]   probability_o,
  output logic [INDEX_W-1:0]  element_index_o,
  output logic                last_result_o
);

  cmd_t cmd;
  sts_t sts;

  smvu_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .last_weight_i (last_weight_i),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .in_stall_o    (in_stall_o)
  );

  smvu_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .weight_i        (weight_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .probability_o   (probability_o),
    .element_index_o (element_index_o),
    .last_result_o   (last_result_o)
  );

endmodule

/* rtl/smvu_checker.sv */
// ----------------------------------------------------------------------------
// smvu_checker
// Port-level checks for the softmax vector unit, bound to the top level.
// ----------------------------------------------------------------------------
module smvu_checker import smvu_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                last_weight_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [PROB_W-1:0]   probability_o,
  input logic [INDEX_W-1:0]  element_index_o,
  input logic                last_result_o
);

  // Hold a stalled result transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(probability_o)
      && $stable(element_index_o) && $stable(last_result_o))
    else $error("stalled result changed");

  // Closing weight starts the passes, so the input stalls next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_weight_i |=> in_stall_o)
    else $error("input not stalled after closing weight");

  // A weight that does not close the vector keeps the input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !last_weight_i |=> !in_stall_o)
    else $error("input stalled during load");

  // A pending result that is not the final one means the vector is still busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_result_o |-> in_stall_o)
    else $error("input open while vector results pending");

endmodule

bind softmax_vector_unit smvu_checker u_smvu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .last_weight_i   (last_weight_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .probability_o   (probability_o),
  .element_index_o (element_index_o),
  .last_result_o   (last_result_o)
);

/* sim/softmax_vector_unit_checker.sv */
// ----------------------------------------------------------------------------
// softmax_vector_unit_checker
// Watches both channels of the softmax vector unit, rebuilds each vector from
// the accepted weight transactions, predicts the normalized Q0.16
// probabilities when the vector closes, and compares every accepted result
// transaction in order. Mismatches and stray results are counted and handed
// to the testbench top.
// ----------------------------------------------------------------------------
module softmax_vector_unit_checker import smvu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  input  logic                last_weight_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [PROB_W-1:0]   probability_i,
  input  logic [INDEX_W-1:0]  element_index_i,
  input  logic                last_result_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PROB_W-1:0]  prob;
    logic [INDEX_W-1:0] idx;
    logic               last;
  } prob_result_t;

  // exp(-2^k/256) in Q0.16 for bit k of the Q8.8 distance from the peak
  localparam logic [EXP_STEPS*16-1:0] STEP_FACTOR = {
    16'd22,    16'd1200,  16'd8869,  16'd24109,
    16'd39750, 16'd51039, 16'd57835, 16'd61565,
    16'd63520, 16'd64520, 16'd65026, 16'd65280
  };
  localparam int unsigned SUM_MAX  = (1 << SUM_W) - 1;
  localparam int unsigned EXP_ONE  = 1 << 16;
  localparam int unsigned EXP_CUT  = 4096;
  localparam int unsigned PROB_MAX = (1 << PROB_W) - 1;

  logic signed [WEIGHT_W-1:0] vec_weights [MAX_ELEMENTS];
  logic signed [WEIGHT_W-1:0] vec_peak;
  int                         vec_len;
  int                         mismatches;
  prob_result_t               expected_probs [$];

  // Bit-serial exp(-u/256) in Q1.16, zero once the distance reaches 16.0
  function automatic int unsigned exp_q16(int unsigned u);
    longint unsigned acc;
    int              k;
    acc = EXP_ONE;
    if (u >= EXP_CUT) return 0;
    for (k = 0; k < EXP_STEPS; k++) begin
      if (u[k]) acc = (acc * STEP_FACTOR[k*16 +: 16] + 32768) >> 16;
    end
    return int'(acc);
  endfunction

  // Sum the exponentials, then queue each element's share in input order
  function automatic void queue_vector_probs();
    int unsigned     e [MAX_ELEMENTS];
    int unsigned     total;
    longint unsigned q;
    int              k;
    prob_result_t    r;
    total = 0;
    for (k = 0; k < vec_len; k++) begin
      e[k]  = int'(vec_peak) - int'(vec_weights[k]);
      e[k]  = exp_q16(e[k]);
      total = total + e[k];
      if (total > SUM_MAX) total = SUM_MAX;
    end
    for (k = 0; k < vec_len; k++) begin
      q = (longint'(e[k]) << 16) / (longint'(total) + 1);
      if (q > PROB_MAX) q = PROB_MAX;
      r.prob = q[PROB_W-1:0];
      r.idx  = INDEX_W'(k);
      r.last = (k == vec_len - 1);
      expected_probs = {expected_probs, r};
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    prob_result_t exp_r;
    if (!rst_ni) begin
      vec_peak = {1'b1, {(WEIGHT_W-1){1'b0}}};
      vec_len = 0;
      mismatches = 0;
      expected_probs.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // Compare each result transaction with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_probs.size() == 0) begin
          $error("unexpected result: probability %0d, element_index %0d, last_result %0d",
                 probability_i, element_index_i, last_result_i);
          mismatches++;
        end else begin
          exp_r = expected_probs.pop_front();
          if (probability_i !== exp_r.prob) begin
            $error("probability mismatch: expected %0d, actual %0d", exp_r.prob, probability_i);
            mismatches++;
          end
          if (element_index_i !== exp_r.idx) begin
            $error("element_index mismatch: expected %0d, actual %0d",
                   exp_r.idx, element_index_i);
            mismatches++;
          end
          if (last_result_i !== exp_r.last) begin
            $error("last_result mismatch: expected %0d, actual %0d", exp_r.last, last_result_i);
            mismatches++;
          end
        end
      end
      // Store the weight unless the vector is full; a closing flag always closes
      if (in_valid_i && !in_stall_i) begin
        if (vec_len < MAX_ELEMENTS) begin
          vec_weights[vec_len] = weight_i;
          if ($signed(weight_i) > vec_peak) vec_peak = weight_i;
          vec_len++;
        end
        if (last_weight_i) begin
          queue_vector_probs();
          vec_peak = {1'b1, {(WEIGHT_W-1){1'b0}}};
          vec_len = 0;
        end
      end
      fail_count_o <= mismatches;
      pending_o <= expected_probs.size();
    end
  end

endmodule

/* sim/softmax_vector_unit_tb.sv */
// ----------------------------------------------------------------------------
// softmax_vector_unit_tb
// Drives weight vectors into the softmax vector unit and judges the run.
// A short directed set covers single elements, equal weights, field extremes
// and the exponent cutoff; random vectors follow, mostly short with a few at
// and past the store depth, under changing sender and receiver idling and one
// long receiver hold-off. The checker predicts and compares the results.
// ----------------------------------------------------------------------------
module softmax_vector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smvu_pkg::*;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_e;
  typedef enum int {MIX_FULL, MIX_NEAR, MIX_EDGE} mix_e;

  localparam int ITEM_TARGET  = 430;
  localparam int PHASE_ITEMS  = 50;
  localparam int HOLD_AT      = 250;
  localparam int HOLD_CYCLES  = 1500;
  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic [WEIGHT_W-1:0] weight_i      = '0;
  logic                last_weight_i = 1'b0;
  logic                out_stall_i   = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [PROB_W-1:0]   probability_o;
  logic [INDEX_W-1:0]  element_index_o;
  logic                last_result_o;

  int items_sent  = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int quiet_count = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int fail_count;
  int pending;

  softmax_vector_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .weight_i       (weight_i),
    .last_weight_i  (last_weight_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .probability_o  (probability_o),
    .element_index_o(element_index_o),
    .last_result_o  (last_result_o)
  );

  softmax_vector_unit_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .weight_i       (weight_i),
    .last_weight_i  (last_weight_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .probability_i  (probability_o),
    .element_index_i(element_index_o),
    .last_result_i  (last_result_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Set the idle and stall rates for one stretch of traffic
  task automatic set_phase(phase_e ph);
    case (ph)
      PH_FREE: begin
        idle_pct = 0;  stall_pct = 0;
      end
      PH_SEND_IDLE: begin
        idle_pct = 52; stall_pct = 0;
      end
      PH_RECV_STALL: begin
        idle_pct = 0;  stall_pct = 52;
      end
      default: begin
        idle_pct = 35; stall_pct = 35;
      end
    endcase
  endtask

  // Offer one weight transaction and hold it until accepted
  task automatic send_weight(logic [WEIGHT_W-1:0] w, logic last);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    weight_i      <= w;
    last_weight_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Send one vector with random content, closed on its final element
  task automatic send_vector(int len);
    mix_e                mix;
    logic [WEIGHT_W-1:0] base;
    logic [WEIGHT_W-1:0] w;
    int                  spread;
    int                  k;
    mix    = mix_e'($urandom_range(2));
    base   = WEIGHT_W'($urandom);
    spread = (1 << $urandom_range(12)) - 1;
    for (k = 0; k < len; k++) begin
      case (mix)
        MIX_FULL: w = WEIGHT_W'($urandom);
        MIX_NEAR: w = base - WEIGHT_W'($urandom_range(spread));
        default: begin
          case ($urandom_range(4))
            0:       w = 16'h7FFF;
            1:       w = 16'h8000;
            2:       w = 16'h0000;
            3:       w = 16'hFFFF;
            default: w = base;
          endcase
        end
      endcase
      send_weight(w, k == len - 1);
    end
  endtask

  // Drive the receiver stall, with one long hold-off partway through
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  // End the run when neither channel moves a transaction for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QUIET_LIMIT) begin
      $display("[softmax_vector_unit] ERROR");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    int r;
    int len;
    set_phase(PH_FREE);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single element: full probability
    send_weight(16'h0000, 1'b1);
    // Field extremes: the smaller one falls far below the cutoff
    send_weight(16'h8000, 1'b0);
    send_weight(16'h7FFF, 1'b1);
    // Equal weights at the top of the range
    send_weight(16'h7FFF, 1'b0);
    send_weight(16'h7FFF, 1'b0);
    send_weight(16'h7FFF, 1'b1);
    // Distances just under, at and over the exponent cutoff
    send_weight(16'h0000, 1'b0);
    send_weight(-16'sd4095, 1'b0);
    send_weight(-16'sd4096, 1'b0);
    send_weight(-16'sd4097, 1'b1);
    // Lone most negative weight
    send_weight(16'h8000, 1'b1);
    // Small spread around zero
    send_weight(16'h0100, 1'b0);
    send_weight(16'h0000, 1'b0);
    send_weight(16'hFF00, 1'b0);
    send_weight(16'h0001, 1'b0);
    send_weight(16'hFFFF, 1'b1);

    // Overfill the store, closing on a dropped weight, then fill it exactly
    send_vector(MAX_ELEMENTS + 6);
    send_vector(MAX_ELEMENTS);

    // Random vectors, mostly short, rotating through the idling phases
    while (items_sent < ITEM_TARGET) begin
      set_phase(phase_e'((items_sent / PHASE_ITEMS) % 4));
      r = $urandom_range(99);
      if (r < 85) len = $urandom_range(12, 1);
      else if (r < 95) len = $urandom_range(MAX_ELEMENTS - 1, 13);
      else len = $urandom_range(MAX_ELEMENTS + 8, MAX_ELEMENTS);
      send_vector(len);
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then let the unit settle
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[softmax_vector_unit] OK");
    end else begin
      $display("[softmax_vector_unit] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/smvu_pkg.sv
rtl/smvu_ram.sv
rtl/smvu_dp.sv
rtl/smvu_ctrl.sv
rtl/softmax_vector_unit.sv
rtl/smvu_checker.sv
sim/softmax_vector_unit_checker.sv
sim/softmax_vector_unit_tb.sv
